// ----- rtl/pidaw_pkg.sv -----
// Shared types and constants of the PID regulator with anti-windup.
// Used by the input interface, the register bank, the datapath and the top level.
// No dependencies.
`default_nettype none

package pidaw_pkg;

  // Item command codes; code three has no meaning and is ignored.
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_MANUAL = 2'd1,
    CMD_AUTO   = 2'd2
  } cmd_t;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DRIVE_MIN     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DRIVE_MAX     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_PERIOD = 3'd5;

  // Register reset values.
  localparam logic [15:0] PROP_GAIN_RST     = 16'h0100;
  localparam logic [15:0] INTEG_GAIN_RST    = 16'h0000;
  localparam logic [15:0] DERIV_GAIN_RST    = 16'h0000;
  localparam logic [15:0] DRIVE_MIN_RST     = 16'h8000;
  localparam logic [15:0] DRIVE_MAX_RST     = 16'h7FFF;
  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd1000;

  // Configuration as seen by the datapath. Signed fields are two's complement.
  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [15:0] drive_min;
    logic [15:0] drive_max;
    logic [15:0] sample_period;
  } pidaw_cfg_t;

  // Controller state; the integral is Q16.8.
  typedef struct packed {
    logic [15:0] held_drive;
    logic [23:0] integral;
    logic [15:0] prev_meas;
    logic [31:0] last_ms;
    logic        auto_on;
  } pidaw_state_t;

  // One input beat.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] time_ms;
    logic [15:0] measured;
    logic [15:0] target;
    logic [15:0] manual_drive;
  } pidaw_item_t;

  // One result beat.
  typedef struct packed {
    logic [15:0] drive;
    logic        updated;
    logic        automatic_res;
  } pidaw_res_t;

endpackage

`default_nettype wire

// ----- rtl/pidaw_in_if.sv -----
// Input channel of the PID regulator: valid/ready handshake and item fields.
// Depends on pidaw_pkg for the command type.
`default_nettype none

interface pidaw_in_if;
  logic               valid;
  logic               ready;
  pidaw_pkg::cmd_t    cmd;
  logic        [31:0] time_ms;
  logic        [15:0] measured;
  logic        [15:0] target;
  logic        [15:0] manual_drive;

  modport source (
    output valid, cmd, time_ms, measured, target, manual_drive,
    input  ready
  );

  modport sink (
    input  valid, cmd, time_ms, measured, target, manual_drive,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/pidaw_out_if.sv -----
// Result channel of the PID regulator: valid/ready handshake and result fields.
// No dependencies.
`default_nettype none

interface pidaw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] drive;
  logic        updated;
  logic        automatic_res;

  modport source (
    output valid, drive, updated, automatic_res,
    input  ready
  );

  modport sink (
    input  valid, drive, updated, automatic_res,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/pidaw_cfg.sv -----
// Configuration register bank of the PID regulator, written through a plain
// write port. Depends on pidaw_pkg.
`default_nettype none

module pidaw_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pidaw_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [pidaw_pkg::CfgDataW-1:0] cfg_wdata,
  output pidaw_pkg::pidaw_cfg_t               cfg
);

  pidaw_pkg::pidaw_cfg_t cfg_r;
  pidaw_pkg::pidaw_cfg_t cfg_nxt;

  // Decode the write to one register; other indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pidaw_pkg::REG_PROP_GAIN:     cfg_nxt.prop_gain     = cfg_wdata;
        pidaw_pkg::REG_INTEG_GAIN:    cfg_nxt.integ_gain    = cfg_wdata;
        pidaw_pkg::REG_DERIV_GAIN:    cfg_nxt.deriv_gain    = cfg_wdata;
        pidaw_pkg::REG_DRIVE_MIN:     cfg_nxt.drive_min     = cfg_wdata;
        pidaw_pkg::REG_DRIVE_MAX:     cfg_nxt.drive_max     = cfg_wdata;
        pidaw_pkg::REG_SAMPLE_PERIOD: cfg_nxt.sample_period = cfg_wdata;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= pidaw_pkg::PROP_GAIN_RST;
      cfg_r.integ_gain    <= pidaw_pkg::INTEG_GAIN_RST;
      cfg_r.deriv_gain    <= pidaw_pkg::DERIV_GAIN_RST;
      cfg_r.drive_min     <= pidaw_pkg::DRIVE_MIN_RST;
      cfg_r.drive_max     <= pidaw_pkg::DRIVE_MAX_RST;
      cfg_r.sample_period <= pidaw_pkg::SAMPLE_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/pidaw_core.sv -----
// Combinational datapath of the PID regulator: from the current state, the
// configuration and one item it forms the next state and the result.
// Depends on pidaw_pkg.
`default_nettype none

module pidaw_core (
  input  wire pidaw_pkg::pidaw_cfg_t   cfg,
  input  wire pidaw_pkg::pidaw_state_t st,
  input  wire pidaw_pkg::pidaw_item_t  item,
  output pidaw_pkg::pidaw_state_t      st_nxt,
  output pidaw_pkg::pidaw_res_t        res
);

  // Clamp that tests the upper limit first, so inverted limits end at one of them.
  function automatic logic signed [34:0] clamp(
    input logic signed [34:0] v,
    input logic signed [34:0] lo,
    input logic signed [34:0] hi
  );
    logic signed [34:0] r;
    if (v > hi) r = hi;
    else if (v < lo) r = lo;
    else r = v;
    return r;
  endfunction

  logic signed [16:0] err;
  logic signed [16:0] dmeas;
  logic signed [32:0] p_prod;
  logic signed [32:0] i_prod;
  logic signed [32:0] d_prod;
  logic signed [34:0] lim_lo_q8;
  logic signed [34:0] lim_hi_q8;
  logic signed [34:0] lim_lo;
  logic signed [34:0] lim_hi;
  logic signed [34:0] integ_ext;
  logic signed [34:0] integ_sum;
  logic signed [34:0] integ_clamped;
  logic signed [34:0] drive_sum;
  logic signed [34:0] drive_floor;
  logic signed [34:0] drive_clamped;
  logic signed [34:0] held_ext;
  logic signed [34:0] held_clamped;
  logic        [31:0] elapsed;
  logic               due;
  logic               upd;

  // Error and measurement step are plain integers, so each product is Q.8.
  assign err   = $signed({item.target[15], item.target}) -
                 $signed({item.measured[15], item.measured});
  assign dmeas = $signed({item.measured[15], item.measured}) -
                 $signed({st.prev_meas[15], st.prev_meas});

  assign p_prod = $signed(cfg.prop_gain) * err;
  assign i_prod = $signed(cfg.integ_gain) * err;
  assign d_prod = $signed(cfg.deriv_gain) * dmeas;

  // Limits in integer and in Q.8 scale.
  assign lim_lo    = {{19{cfg.drive_min[15]}}, cfg.drive_min};
  assign lim_hi    = {{19{cfg.drive_max[15]}}, cfg.drive_max};
  assign lim_lo_q8 = {{11{cfg.drive_min[15]}}, cfg.drive_min, 8'h00};
  assign lim_hi_q8 = {{11{cfg.drive_max[15]}}, cfg.drive_max, 8'h00};

  // Integral update with anti-windup clamp.
  assign integ_ext     = {{11{st.integral[23]}}, st.integral};
  assign integ_sum     = integ_ext + {{2{i_prod[32]}}, i_prod};
  assign integ_clamped = clamp(integ_sum, lim_lo_q8, lim_hi_q8);

  // Drive sum in Q.8, floored to an integer, then clamped.
  assign drive_sum     = {{2{p_prod[32]}}, p_prod} + integ_clamped -
                         {{2{d_prod[32]}}, d_prod};
  assign drive_floor   = drive_sum >>> 8;
  assign drive_clamped = clamp(drive_floor, lim_lo, lim_hi);

  // Bumpless start loads the clamped held drive into the integral.
  assign held_ext     = {{19{st.held_drive[15]}}, st.held_drive};
  assign held_clamped = clamp(held_ext, lim_lo, lim_hi);

  // Elapsed time wraps modulo 2^32.
  assign elapsed = item.time_ms - st.last_ms;
  assign due     = elapsed >= {16'h0000, cfg.sample_period};

  // Command decode and state update.
  always_comb begin
    st_nxt = st;
    upd    = 1'b0;
    case (item.cmd)
      pidaw_pkg::CMD_SAMPLE: begin
        if (st.auto_on && due) begin
          st_nxt.integral   = integ_clamped[23:0];
          st_nxt.held_drive = drive_clamped[15:0];
          st_nxt.prev_meas  = item.measured;
          st_nxt.last_ms    = item.time_ms;
          upd               = 1'b1;
        end
      end
      pidaw_pkg::CMD_MANUAL: begin
        st_nxt.held_drive = item.manual_drive;
        st_nxt.auto_on    = 1'b0;
      end
      pidaw_pkg::CMD_AUTO: begin
        if (!st.auto_on) begin
          st_nxt.prev_meas = item.measured;
          st_nxt.integral  = {held_clamped[15:0], 8'h00};
        end
        st_nxt.auto_on = 1'b1;
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

  assign res.drive         = st_nxt.held_drive;
  assign res.updated       = upd;
  assign res.automatic_res = st_nxt.auto_on;

endmodule

`default_nettype wire

// ----- rtl/pid_controller_antiwindup_top.sv -----
// PID regulator with clamped integral and derivative on the measurement.
//
// Channels: in_ch takes one item per beat (sample, set manual, set automatic);
// out_ch returns exactly one result beat per item, in order: the held drive,
// whether this item computed a new drive, and the current mode. The cfg port
// writes the gain, limit and sample period registers; write only while idle.
//
// Pipeline: an accepted item is held in the input register, and its result is
// loaded into the output register once the result slot is free, which raises
// out valid. Throughput is one item per cycle while out_ch stays ready:
// the state update is a single pass of three 16x17 multiplies, two adds
// and three clamps from the input register to the state and result registers.
//
// Reset (synchronous, rst_n low): both pipeline registers empty, controller
// state zero in manual mode, registers at their reset values.
// Stall: while out_ch is not ready the result stays put, the input register
// keeps one more item, and in_ch ready drops once both are full.
// Depends on pidaw_pkg, pidaw_in_if, pidaw_out_if, pidaw_cfg, pidaw_core.
`default_nettype none

module pid_controller_antiwindup_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pidaw_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [pidaw_pkg::CfgDataW-1:0] cfg_wdata,
  pidaw_in_if.sink                            in_ch,
  pidaw_out_if.source                         out_ch
);

  pidaw_pkg::pidaw_cfg_t   cfg;
  pidaw_pkg::pidaw_state_t st_r;
  pidaw_pkg::pidaw_state_t st_nxt;
  pidaw_pkg::pidaw_item_t  s1_item_r;
  pidaw_pkg::pidaw_res_t   res_nxt;
  pidaw_pkg::pidaw_res_t   out_res_r;
  logic                    s1_valid_r;
  logic                    out_valid_r;
  logic                    s1_adv;
  logic                    in_take;

  // Register bank.
  pidaw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Datapath between the input register and the state/result registers.
  pidaw_core u_core (
    .cfg    (cfg),
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Handshake: the input register moves on whenever the result slot is free.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.cmd          <= in_ch.cmd;
      s1_item_r.time_ms      <= in_ch.time_ms;
      s1_item_r.measured     <= in_ch.measured;
      s1_item_r.target       <= in_ch.target;
      s1_item_r.manual_drive <= in_ch.manual_drive;
    end
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive         = out_res_r.drive;
  assign out_ch.updated       = out_res_r.updated;
  assign out_ch.automatic_res = out_res_r.automatic_res;

  // A new drive is only ever computed in automatic mode.
  a_upd_auto: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.updated |-> out_res_r.automatic_res)
    else $error("updated result reported outside automatic mode");

  // A set-manual item always leaves the controller in manual mode.
  a_manual_off: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_item_r.cmd == pidaw_pkg::CMD_MANUAL) |=> !st_r.auto_on)
    else $error("controller still automatic after a set-manual item");

  // The controller state does not move while the pipeline is stalled.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> $stable(st_r))
    else $error("controller state changed during a stall");

  // A result slot that is full and not taken stays full.
  a_out_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r)
    else $error("result dropped while the receiver stalled");

endmodule

`default_nettype wire

// ----- tb/pid_controller_antiwindup_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for pid_controller_antiwindup_top: directed and random beats,
// a built-in predictor of the regulator, random idling and a long result hold-off.
// Depends on pidaw_pkg, pidaw_in_if, pidaw_out_if and the top-level RTL.

module pid_controller_antiwindup_top_tb;

  // Command code three carries no meaning; the block must ignore it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 6;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [pidaw_pkg::CfgIdxW-1:0] cfg_index;
  logic [pidaw_pkg::CfgDataW-1:0] cfg_wdata;

  pidaw_in_if in_ch ();
  pidaw_out_if out_ch ();

  pid_controller_antiwindup_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor copy of the registers and the controller state.
  logic signed [15:0] kp, ki, kd, lim_lo, lim_hi;
  logic [15:0] period_ms;
  logic signed [15:0] held_drive_m;
  longint integ_m;
  logic signed [15:0] prev_meas_m;
  logic [31:0] last_ms_m;
  logic auto_m;

  pidaw_pkg::pidaw_res_t pending_results[$];
  int mismatch_count = 0;
  int idle_cycles = 0;

  // Stimulus controls shared by the sender and the result sink.
  bit burst = 1'b0;
  bit hold_request = 1'b0;
  bit auto_sent = 1'b0;
  logic [31:0] clock_ms = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    // The upper limit is tested first, so inverted limits end at one of the two.
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void reset_model();
    kp = pidaw_pkg::PROP_GAIN_RST;
    ki = pidaw_pkg::INTEG_GAIN_RST;
    kd = pidaw_pkg::DERIV_GAIN_RST;
    lim_lo = pidaw_pkg::DRIVE_MIN_RST;
    lim_hi = pidaw_pkg::DRIVE_MAX_RST;
    period_ms = pidaw_pkg::SAMPLE_PERIOD_RST;
    held_drive_m = '0;
    integ_m = 0;
    prev_meas_m = '0;
    last_ms_m = '0;
    auto_m = 1'b0;
  endfunction

  function automatic void apply_reg(logic [pidaw_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
    case (idx)
      pidaw_pkg::REG_PROP_GAIN:     kp = val;
      pidaw_pkg::REG_INTEG_GAIN:    ki = val;
      pidaw_pkg::REG_DERIV_GAIN:    kd = val;
      pidaw_pkg::REG_DRIVE_MIN:     lim_lo = val;
      pidaw_pkg::REG_DRIVE_MAX:     lim_hi = val;
      pidaw_pkg::REG_SAMPLE_PERIOD: period_ms = val;
      default: ;
    endcase
  endfunction

  // Advances the regulator by one item and returns the result beat it causes.
  function automatic pidaw_pkg::pidaw_res_t regulate(logic [1:0] cmd, logic [31:0] now,
                                                     logic signed [15:0] meas,
                                                     logic signed [15:0] tgt,
                                                     logic signed [15:0] mdrive);
    pidaw_pkg::pidaw_res_t res;
    longint err, dmeas, sum;
    logic [31:0] elapsed;
    logic upd;
    upd = 1'b0;
    elapsed = now - last_ms_m;
    case (cmd)
      pidaw_pkg::CMD_SAMPLE: begin
        if (auto_m && elapsed >= 32'(period_ms)) begin
          err = longint'(tgt) - longint'(meas);
          dmeas = longint'(meas) - longint'(prev_meas_m);
          integ_m = clamp_to(integ_m + longint'(ki) * err,
                             longint'(lim_lo) * 256, longint'(lim_hi) * 256);
          sum = longint'(kp) * err + integ_m - longint'(kd) * dmeas;
          // Arithmetic shift floors the Q.8 sum to an integer drive.
          held_drive_m = 16'(clamp_to(sum >>> 8, lim_lo, lim_hi));
          prev_meas_m = meas;
          last_ms_m = now;
          upd = 1'b1;
        end
      end
      pidaw_pkg::CMD_MANUAL: begin
        held_drive_m = mdrive;
        auto_m = 1'b0;
      end
      pidaw_pkg::CMD_AUTO: begin
        // Bumpless start: latch the measurement and seed the integral.
        if (!auto_m) begin
          prev_meas_m = meas;
          integ_m = clamp_to(longint'(held_drive_m) * 256,
                             longint'(lim_lo) * 256, longint'(lim_hi) * 256);
        end
        auto_m = 1'b1;
      end
      default: ;
    endcase
    res.drive = held_drive_m;
    res.updated = upd;
    res.automatic_res = auto_m;
    return res;
  endfunction

  // Track register writes and predict every accepted input beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_we) apply_reg(cfg_index, cfg_wdata);
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(regulate(in_ch.cmd, in_ch.time_ms, in_ch.measured,
                                           in_ch.target, in_ch.manual_drive));
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin : check_results
    pidaw_pkg::pidaw_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected: drive %0d updated %0b auto %0b",
                 $time, $signed(out_ch.drive), out_ch.updated, out_ch.automatic_res);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.drive !== want.drive || out_ch.updated !== want.updated ||
            out_ch.automatic_res !== want.automatic_res) begin
          $display({"%0t: expected drive %0d updated %0b auto %0b, ",
                    "got drive %0d updated %0b auto %0b"},
                   $time, $signed(want.drive), want.updated, want.automatic_res,
                   $signed(out_ch.drive), out_ch.updated, out_ch.automatic_res);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no beat and no write moves for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, nothing accepted for %0d cycles", $time, idle_cycles);
      $display("pid_controller_antiwindup_top test failed");
      $finish;
    end
  end

  // Result sink: random stall before each beat, plus one long hold-off on request.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = burst ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Offers one input beat after a random gap and returns once it is accepted.
  task automatic send_beat(input logic [1:0] cmd, input logic [31:0] now,
                           input logic [15:0] meas, input logic [15:0] tgt,
                           input logic [15:0] mdrive);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= pidaw_pkg::cmd_t'(cmd);
    in_ch.time_ms <= now;
    in_ch.measured <= meas;
    in_ch.target <= tgt;
    in_ch.manual_drive <= mdrive;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == pidaw_pkg::CMD_AUTO) auto_sent = 1'b1;
    else if (cmd == pidaw_pkg::CMD_MANUAL) auto_sent = 1'b0;
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all six registers while the block is idle.
  task automatic load_settings(input logic [15:0] p_gain, i_gain, d_gain, lo, hi, per);
    logic [pidaw_pkg::CfgIdxW-1:0] idx [6];
    logic [15:0] val [6];
    idx = '{pidaw_pkg::REG_PROP_GAIN, pidaw_pkg::REG_INTEG_GAIN,
            pidaw_pkg::REG_DERIV_GAIN, pidaw_pkg::REG_DRIVE_MIN,
            pidaw_pkg::REG_DRIVE_MAX, pidaw_pkg::REG_SAMPLE_PERIOD};
    val = '{p_gain, i_gain, d_gain, lo, hi, per};
    drain();
    for (int k = 0; k < 6; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random beats: mostly samples in automatic mode with time stepping past the
  // period, mixed with early samples, time jumps, mode changes and the unused code.
  task automatic run_random(input int count);
    int pick;
    int step;
    logic [1:0] cmd;
    logic [15:0] meas, tgt;
    logic [31:0] now;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (!auto_sent) begin
        if (pick < 50) cmd = pidaw_pkg::CMD_AUTO;
        else if (pick < 60) cmd = pidaw_pkg::CMD_MANUAL;
        else if (pick < 65) cmd = CMD_UNUSED;
        else cmd = pidaw_pkg::CMD_SAMPLE;
      end else begin
        if (pick < 86) cmd = pidaw_pkg::CMD_SAMPLE;
        else if (pick < 91) cmd = pidaw_pkg::CMD_MANUAL;
        else if (pick < 96) cmd = pidaw_pkg::CMD_AUTO;
        else cmd = CMD_UNUSED;
      end
      if (cmd == pidaw_pkg::CMD_SAMPLE) begin
        step = $urandom_range(0, 9);
        if (step < 7)
          clock_ms += 32'(period_ms) + $urandom_range(0, 32'(period_ms) / 4 + 3);
        else if (step < 9 && period_ms != 0)
          clock_ms += $urandom_range(0, 32'(period_ms) - 1);
        else
          clock_ms = $urandom();
        now = clock_ms;
      end else begin
        now = $urandom();
      end
      meas = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 400) - 200);
      tgt = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 400) - 200);
      send_beat(cmd, now, meas, tgt, 16'($urandom()));
    end
  endtask

  // Reset settings, then extreme ones: every command, field extremes, the period boundary.
  task automatic test_directed_defaults();
    send_beat(pidaw_pkg::CMD_SAMPLE, 32'd5000, 16'd10, 16'd20, 16'd0);
    send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(pidaw_pkg::CMD_MANUAL, 32'd0, 16'd0, 16'd0, 16'h7FFF);
    send_beat(pidaw_pkg::CMD_MANUAL, 32'd0, 16'd0, 16'd0, 16'h8000);
    send_beat(pidaw_pkg::CMD_MANUAL, 32'd0, 16'd0, 16'd0, 16'd300);
    send_beat(pidaw_pkg::CMD_AUTO, 32'd0, 16'h8000, 16'd0, 16'd0);
    send_beat(pidaw_pkg::CMD_AUTO, 32'd0, 16'd500, 16'd0, 16'd0);
    // Sample one millisecond short of the period: no update.
    send_beat(pidaw_pkg::CMD_SAMPLE, 32'd999, 16'd0, 16'd0, 16'hFFFF);
    send_beat(pidaw_pkg::CMD_SAMPLE, 32'd1000, 16'h7FFF, 16'h8000, 16'd0);
    send_beat(pidaw_pkg::CMD_SAMPLE, 32'd2000, 16'h8000, 16'h7FFF, 16'd0);
    send_beat(pidaw_pkg::CMD_SAMPLE, 32'd2999, 16'd5, 16'd9, 16'd0);
    send_beat(pidaw_pkg::CMD_MANUAL, 32'd0, 16'd0, 16'd0, 16'd0);
    send_beat(CMD_UNUSED, 32'd0, 16'd0, 16'd0, 16'd0);

    // Extreme gains, narrow limits and the longest period.
    load_settings(16'h8000, 16'h7FFF, 16'h8000, 16'(-100), 16'd100, 16'hFFFF);
    send_beat(pidaw_pkg::CMD_MANUAL, 32'd0, 16'd0, 16'd0, 16'd20000);
    send_beat(pidaw_pkg::CMD_AUTO, 32'd0, 16'd7, 16'd0, 16'd0);
    send_beat(pidaw_pkg::CMD_SAMPLE, 32'hFFFF_0000, 16'd0, 16'd1, 16'd0);
    // Elapsed time is taken across the wrap of the millisecond counter.
    send_beat(pidaw_pkg::CMD_SAMPLE, 32'h0000_FFFE, 16'd3, 16'd1, 16'd0);
    send_beat(pidaw_pkg::CMD_SAMPLE, 32'h0000_FFFF, 16'd3, 16'd1, 16'd0);
    send_beat(pidaw_pkg::CMD_SAMPLE, 32'h0001_FFFD, 16'hFFF0, 16'd40, 16'd0);
    clock_ms = 32'h0001_FFFD;
  endtask

  // Minimum limit above the maximum: every computed drive lands on one of them.
  task automatic test_inverted_limits();
    load_settings(16'd256, 16'd128, 16'd256, 16'd500, 16'(-500), 16'd3);
    send_beat(pidaw_pkg::CMD_MANUAL, 32'd0, 16'd0, 16'd0, 16'd0);
    send_beat(pidaw_pkg::CMD_AUTO, 32'd0, 16'd10, 16'd0, 16'd0);
    send_beat(pidaw_pkg::CMD_SAMPLE, clock_ms + 32'd3, 16'd10, 16'd20, 16'd0);
    send_beat(pidaw_pkg::CMD_SAMPLE, clock_ms + 32'd7, 16'd30, 16'd20, 16'd0);
    clock_ms += 32'd7;
    run_random(40);
  endtask

  // Zero period: every sample in automatic mode updates, even at the same time.
  task automatic test_zero_period();
    load_settings(16'd200, 16'd50, 16'hFF00, 16'(-2000), 16'd2000, 16'd0);
    send_beat(pidaw_pkg::CMD_AUTO, 32'd0, 16'd0, 16'd0, 16'd0);
    repeat (4)
      send_beat(pidaw_pkg::CMD_SAMPLE, clock_ms, 16'($urandom_range(0, 200)),
                16'd100, 16'd0);
    run_random(40);
  endtask

  // The result side holds off for a long stretch while beats keep coming.
  task automatic test_backpressure();
    load_settings(16'd256, 16'd16, 16'd64, 16'(-1000), 16'd1000, 16'd10);
    hold_request = 1'b1;
    burst = 1'b1;
    run_random(30);
    burst = 1'b0;
  endtask

  // Several register settings with random beats, one phase without idling.
  task automatic test_random_sweep();
    load_settings(16'd256, 16'd16, 16'd64, 16'(-1000), 16'd1000, 16'd10);
    run_random(64);
    load_settings(16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'h8000, 16'h7FFF, 16'd1);
    run_random(64);
    load_settings(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
    run_random(64);
    load_settings(16'd64, 16'd8, 16'(-32), 16'(-50), 16'd300, 16'd100);
    burst = 1'b1;
    run_random(64);
    burst = 1'b0;
    load_settings(16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()), 16'($urandom()), 16'($urandom_range(1, 50)));
    run_random(64);
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= pidaw_pkg::CMD_SAMPLE;
    in_ch.time_ms <= '0;
    in_ch.measured <= '0;
    in_ch.target <= '0;
    in_ch.manual_drive <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_defaults();
    test_inverted_limits();
    test_zero_period();
    test_backpressure();
    test_random_sweep();
    drain();

    if (mismatch_count == 0)
      $display("pid_controller_antiwindup_top test passed");
    else
      $display("pid_controller_antiwindup_top test failed");
    $finish;
  end

endmodule
